// ===== rtl/core/psr_pkg.sv =====
// ----------------------------------------------------------------------------
// psr_pkg: shared constants and coefficient functions
// Defaults for the resampler, fixed field widths, and the elaboration-time
// generator of the windowed-sinc coefficient table.
// ----------------------------------------------------------------------------
package psr_pkg;

	localparam int PHASE_BITS_DEF   = 8;
	localparam int TAP_BITS_DEF     = 3;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// coefficients are Q2.14
	localparam int COEF_W    = 16;
	localparam int COEF_FRAC = 14;

	// rate_step register
	localparam int STEP_W = 12;
	localparam logic [STEP_W-1:0] STEP_RESET = 12'd256;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] PI_Q30  = 64'd3373259426;

	// Shift-subtract division, elaboration use only.
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d,
			input bit want_rem);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return want_rem ? r : q;
	endfunction

	// sin(t)/t for t in [0, pi/2], Q30 in and out
	function automatic logic [63:0] sinc_poly(input logic [63:0] t);
		logic [63:0] t2;
		logic [63:0] term;
		logic [63:0] sum;
		t2   = (t * t) >> 30;
		term = Q30_ONE;
		sum  = Q30_ONE;
		for (int k = 1; k <= 8; k++) begin
			term = (term * t2) >> 30;
			term = udiv(term, 64'((2 * k) * (2 * k + 1)), 1'b0);
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		return sum;
	endfunction

	// sinc(n/d) in signed Q30, d > 0
	function automatic longint sinc_ratio(input longint n, input logic [63:0] d);
		logic [63:0] a;
		logic [63:0] r;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] den;
		logic [63:0] q;
		bit          neg;
		a   = (n < 0) ? 64'(-n) : 64'(n);
		neg = 1'b0;
		if (a == 64'd0)
			return longint'(Q30_ONE);
		r = udiv(a, d << 1, 1'b1);
		if (r >= d) begin
			r   = r - d;
			neg = 1'b1;
		end
		if ((r << 1) > d)
			r = d - r;
		t = udiv(PI_Q30 * r + (d >> 1), d, 1'b0);
		if ((a << 1) <= d)
			return longint'(sinc_poly(t));
		s   = (t * sinc_poly(t)) >> 30;
		den = udiv(PI_Q30 * a + (d >> 1), d, 1'b0);
		q   = udiv((s << 30) + (den >> 1), den, 1'b0);
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// Coefficient of phase p, tap k (tap 0 multiplies the oldest sample)
	function automatic logic signed [COEF_W-1:0] coef_value(input int p, input int k,
			input int pb, input int tb);
		longint      nph;
		longint      nt;
		longint      len;
		longint      i;
		longint      h;
		longint      w;
		logic [63:0] mh;
		logic [63:0] mw;
		logic [63:0] m;
		nph = longint'(1) << pb;
		nt  = longint'(1) << tb;
		len = nph * nt;
		i   = (nt - 1 - longint'(k)) * nph + longint'(p);
		h   = sinc_ratio(i - (len >> 1), 64'(nph));
		w   = sinc_ratio(2 * i - (len - 1), 64'(len - 1));
		mh  = (h < 0) ? 64'(-h) : 64'(h);
		mw  = (w < 0) ? 64'(-w) : 64'(w);
		m   = (mh * mw + (64'd1 << 45)) >> 46;
		return ((h < 0) != (w < 0)) ? -COEF_W'(m) : COEF_W'(m);
	endfunction

endpackage

// ===== rtl/core/polyphase_sinc_resampler.sv =====
// ----------------------------------------------------------------------------
// polyphase_sinc_resampler: polyphase windowed-sinc rate converter
// Top level: sample queue (front), conversion engine and coefficient ROM
// (back), result queue, and the rate_step register.
// ----------------------------------------------------------------------------
// Usage:
//  Input side is a queue: present sample_in/last_in with push; a transfer
//  happens on a clock edge with push high and full low. A two-entry sample
//  queue lets the source keep pushing while the engine works.
//  Output side is a queue: while empty is low, sample_out/last_of_run hold
//  the oldest result; pop high with empty low transfers it. last_of_run
//  marks the final result caused by one input sample.
//  Each input causes zero or more results (at most 64). Per result the
//  engine issues its NTAPS taps (8 by default) one per cycle into the
//  single shared multiplier, passes the ROM read and product register
//  stages and hands over the rounded sum. An input that completes no
//  window only shifts into the delay line.
//  If the result queue fills, the engine holds in its hand-over cycle and
//  the sample queue backs up until full rises; nothing is dropped.
//  Reset zeroes the delay line and the phase, sets the wait count to
//  NTAPS, empties both queues and loads rate_step with 256. After a
//  last_in sample, delay line, phase and wait count reset; queues, rate_step
//  stay. Write rate_step (cfg_we/cfg_wdata) only while the block is idle.
// ----------------------------------------------------------------------------
module polyphase_sinc_resampler #(
	parameter int PHASE_BITS   = psr_pkg::PHASE_BITS_DEF,
	parameter int TAP_BITS     = psr_pkg::TAP_BITS_DEF,
	parameter int SAMPLE_WIDTH = psr_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [psr_pkg::STEP_W-1:0]        cfg_wdata,
	// input queue
	input  logic                              push,
	output logic                              full,
	input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
	input  logic                              last_in,
	// output queue
	output logic                              empty,
	input  logic                              pop,
	output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
	output logic                              last_of_run
);
	import psr_pkg::*;

	localparam int ITEM_W = SAMPLE_WIDTH + 1;

	logic [STEP_W-1:0]               rate_step_q;

	logic [ITEM_W-1:0]               in_item;
	logic                            in_empty;
	logic                            in_pop;
	logic                            res_full;
	logic                            res_push;
	logic signed [SAMPLE_WIDTH-1:0]  res_sample;
	logic                            res_last;
	logic [ITEM_W-1:0]               out_item;
	logic [PHASE_BITS+TAP_BITS-1:0]  rom_addr;
	logic signed [COEF_W-1:0]        rom_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rate_step_q <= STEP_RESET;
		else if (cfg_we)
			rate_step_q <= cfg_wdata;
	end

	// front: sample queue
	psr_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (2)
	) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({last_in, sample_in}),
		.full   (full),
		.pop    (in_pop),
		.rdata  (in_item),
		.empty  (in_empty)
	);

	// back: conversion engine
	psr_engine #(
		.PHASE_BITS   (PHASE_BITS),
		.TAP_BITS     (TAP_BITS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.rate_step  (rate_step_q),
		.in_empty   (in_empty),
		.in_pop     (in_pop),
		.in_sample  (in_item[SAMPLE_WIDTH-1:0]),
		.in_last    (in_item[SAMPLE_WIDTH]),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_sample (res_sample),
		.res_last   (res_last),
		.rom_addr   (rom_addr),
		.rom_data   (rom_data)
	);

	psr_coef_rom #(
		.PHASE_BITS (PHASE_BITS),
		.TAP_BITS   (TAP_BITS)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	// result queue decouples engine from the consumer
	psr_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (2)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  ({res_last, res_sample}),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_item),
		.empty  (empty)
	);

	assign sample_out  = out_item[SAMPLE_WIDTH-1:0];
	assign last_of_run = out_item[SAMPLE_WIDTH];

endmodule

// ===== rtl/core/psr_fifo.sv =====
// ----------------------------------------------------------------------------
// psr_fifo: small register queue
// Push/full on the write side, pop/empty on the read side; head is shown
// combinationally from the storage registers.
// ----------------------------------------------------------------------------
module psr_fifo #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == (AW + 1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop_ok)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push_ok && !pop_ok)
				cnt_q <= cnt_q + 1'b1;
			else if (pop_ok && !push_ok)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok)
			mem_q[wr_q] <= wdata;
	end

endmodule

// ===== rtl/core/psr_coef_rom.sv =====
// ----------------------------------------------------------------------------
// psr_coef_rom: polyphase coefficient ROM
// Lanczos-windowed sinc prototype, split into phases and reversed; table is
// built at elaboration, read data registered. Address is {phase, tap}.
// ----------------------------------------------------------------------------
module psr_coef_rom #(
	parameter int PHASE_BITS = psr_pkg::PHASE_BITS_DEF,
	parameter int TAP_BITS   = psr_pkg::TAP_BITS_DEF
) (
	input  logic                                clk,
	input  logic [PHASE_BITS+TAP_BITS-1:0]      addr,
	output logic signed [psr_pkg::COEF_W-1:0]   data
);
	import psr_pkg::*;

	localparam int NPHASES   = 1 << PHASE_BITS;
	localparam int NTAPS     = 1 << TAP_BITS;
	localparam int ROM_DEPTH = NPHASES * NTAPS;

	typedef logic signed [COEF_W-1:0] rom_t [ROM_DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		for (int p = 0; p < NPHASES; p++)
			for (int k = 0; k < NTAPS; k++)
				r[p * NTAPS + k] = coef_value(p, k, PHASE_BITS, TAP_BITS);
		return r;
	endfunction

	localparam rom_t ROM_TABLE = build_rom();

	always_ff @(posedge clk) begin
		data <= ROM_TABLE[addr];
	end

endmodule

// ===== rtl/core/psr_engine.sv =====
// ----------------------------------------------------------------------------
// psr_engine: back end of the resampler
// Takes queued samples into the delay line, tracks the fractional read
// position, and runs one shared multiply-accumulate per tap per output.
// ----------------------------------------------------------------------------
module psr_engine #(
	parameter int PHASE_BITS   = psr_pkg::PHASE_BITS_DEF,
	parameter int TAP_BITS     = psr_pkg::TAP_BITS_DEF,
	parameter int SAMPLE_WIDTH = psr_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [psr_pkg::STEP_W-1:0]          rate_step,
	// sample queue
	input  logic                                in_empty,
	output logic                                in_pop,
	input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
	input  logic                                in_last,
	// result queue
	input  logic                                res_full,
	output logic                                res_push,
	output logic signed [SAMPLE_WIDTH-1:0]      res_sample,
	output logic                                res_last,
	// coefficient ROM
	output logic [PHASE_BITS+TAP_BITS-1:0]      rom_addr,
	input  logic signed [psr_pkg::COEF_W-1:0]   rom_data
);
	import psr_pkg::*;

	localparam int NPHASES = 1 << PHASE_BITS;
	localparam int NTAPS   = 1 << TAP_BITS;
	localparam int FLOOR_B = (NPHASES + 63) / 64;
	localparam logic [STEP_W-1:0] STEP_FLOOR = STEP_W'((FLOOR_B > 4) ? FLOOR_B : 4);
	localparam int SUM_W   = STEP_W + 1;
	localparam int WAIT_W  = (TAP_BITS + 1 > STEP_W + 1 - PHASE_BITS) ?
		TAP_BITS + 1 : STEP_W + 1 - PHASE_BITS;
	localparam int PROD_W  = SAMPLE_WIDTH + COEF_W;
	localparam int ACC_W   = PROD_W + TAP_BITS + 1;
	localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1 << (COEF_FRAC - 1));

	typedef enum logic [1:0] {
		S_IDLE,
		S_MAC,
		S_EMIT
	} state_t;

	state_t                         state_q;
	logic signed [SAMPLE_WIDTH-1:0] dl_q [NTAPS];
	logic [PHASE_BITS-1:0]          phase_q;
	logic [WAIT_W-1:0]              wait_q;
	logic                           last_q;
	logic [TAP_BITS-1:0]            k_q;
	logic                           issue_q;
	logic                           vld_s1;
	logic                           vld_s2;
	logic [TAP_BITS-1:0]            k_s1;
	logic [TAP_BITS-1:0]            k_s2;
	logic signed [PROD_W-1:0]       prod_s2;
	logic signed [ACC_W-1:0]        acc_q;

	logic [STEP_W-1:0]              step_eff;
	logic [SUM_W-1:0]               pos_sum;
	logic [WAIT_W-1:0]              adv;
	logic [WAIT_W-1:0]              wait_dec;
	logic signed [PROD_W-1:0]       mul_d;
	logic signed [ACC_W-1:0]        rnd_d;
	logic signed [ACC_W-1:0]        shr_d;

	assign step_eff = (rate_step < STEP_FLOOR) ? STEP_FLOOR : rate_step;
	assign pos_sum  = SUM_W'(phase_q) + SUM_W'(step_eff);
	assign adv      = WAIT_W'(pos_sum >> PHASE_BITS);
	assign wait_dec = (wait_q == '0) ? '0 : wait_q - 1'b1;

	assign in_pop   = (state_q == S_IDLE) && !in_empty;
	assign res_push = (state_q == S_EMIT) && !res_full;
	assign res_last = (adv != '0);
	assign rom_addr = {phase_q, k_q};

	assign mul_d = dl_q[k_s1] * rom_data;

	// round half up at Q.14, then saturate
	assign rnd_d = acc_q + RND;
	assign shr_d = rnd_d >>> COEF_FRAC;
	always_comb begin
		if (shr_d > SMAX)
			res_sample = SAMPLE_WIDTH'(SMAX);
		else if (shr_d < SMIN)
			res_sample = SAMPLE_WIDTH'(SMIN);
		else
			res_sample = SAMPLE_WIDTH'(shr_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int j = 0; j < NTAPS; j++)
				dl_q[j] <= '0;
			phase_q <= '0;
			wait_q  <= WAIT_W'(NTAPS);
			last_q  <= 1'b0;
			k_q     <= '0;
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			acc_q   <= '0;
		end else begin
			vld_s1 <= issue_q;
			vld_s2 <= vld_s1;
			if (vld_s2)
				acc_q <= acc_q + ACC_W'(prod_s2);

			case (state_q)
				S_IDLE: begin
					if (in_pop) begin
						for (int j = 0; j < NTAPS - 1; j++)
							dl_q[j] <= dl_q[j + 1];
						dl_q[NTAPS-1] <= in_sample;
						last_q <= in_last;
						if (wait_dec == '0) begin
							wait_q  <= '0;
							state_q <= S_MAC;
							k_q     <= '0;
							issue_q <= 1'b1;
							acc_q   <= '0;
						end else if (in_last) begin
							for (int j = 0; j < NTAPS; j++)
								dl_q[j] <= '0;
							phase_q <= '0;
							wait_q  <= WAIT_W'(NTAPS);
						end else begin
							wait_q <= wait_dec;
						end
					end
				end
				S_MAC: begin
					if (issue_q) begin
						k_q <= k_q + 1'b1;
						if (k_q == TAP_BITS'(NTAPS - 1))
							issue_q <= 1'b0;
					end
					if (vld_s2 && k_s2 == TAP_BITS'(NTAPS - 1))
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (res_push) begin
						phase_q <= pos_sum[PHASE_BITS-1:0];
						if (adv == '0) begin
							// window still complete: next output from same input
							state_q <= S_MAC;
							k_q     <= '0;
							issue_q <= 1'b1;
							acc_q   <= '0;
						end else if (last_q) begin
							for (int j = 0; j < NTAPS; j++)
								dl_q[j] <= '0;
							phase_q <= '0;
							wait_q  <= WAIT_W'(NTAPS);
							state_q <= S_IDLE;
						end else begin
							wait_q  <= adv;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath stages, no reset needed
	always_ff @(posedge clk) begin
		k_s1    <= k_q;
		k_s2    <= k_s1;
		prod_s2 <= mul_d;
	end

endmodule

// ===== rtl/core/psr_checker.sv =====
// ----------------------------------------------------------------------------
// psr_checker: port-level checks for the resampler
// Reset state of the queues, result hold under stall, and known result data.
// ----------------------------------------------------------------------------
module psr_checker #(
	parameter int SAMPLE_WIDTH = psr_pkg::SAMPLE_WIDTH_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    push,
	input logic                    full,
	input logic                    empty,
	input logic                    pop,
	input logic [SAMPLE_WIDTH-1:0] sample_out,
	input logic                    last_of_run
);

	// the result queue comes out of reset empty, the sample queue not full
	a_reset_queues: assert property (@(posedge clk) !arst_n |=> (empty && !full))
		else $error("queues not empty after reset");

	// a waiting result stays until popped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result vanished without a pop");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(sample_out) && $stable(last_of_run)))
		else $error("stalled result changed");

	// a result on the ports carries no unknown bits
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown({sample_out, last_of_run}))
		else $error("result has unknown bits");

endmodule

bind polyphase_sinc_resampler psr_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_psr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.push        (push),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.sample_out  (sample_out),
	.last_of_run (last_of_run)
);
